// File: rtl/icrb_pkg.sv
// Package: constants, types and arithmetic helpers of the reflect-border convolution filter.
`default_nettype none
package icrb_pkg;

    localparam int MAX_WIDTH        = 1024;
    localparam int MAX_RADIUS       = 7;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int KSIDE            = 2 * MAX_RADIUS + 1;
    localparam int TAP_COUNT        = KSIDE * KSIDE;
    localparam int RING_ROWS        = 16;
    localparam int RING_DEPTH       = RING_ROWS * MAX_WIDTH;
    localparam int MIN_DIM          = 16;
    localparam int MAX_HEIGHT       = 4096;

    localparam int CNT_W   = 23;
    localparam int ACC_W   = 34;
    localparam int PROD_W  = 25;
    localparam int DIV_STEPS = CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVI,
        S_WRITE,
        S_DIVO,
        S_TAPS,
        S_FLUSH,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_TAP   = 2'd0,
        OP_PIXEL = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    // reflect-101: -1 -> 1, n -> n-2
    function automatic logic [12:0] mirror(input logic signed [14:0] t, input logic [12:0] n);
        logic signed [14:0] a;
        logic signed [14:0] nm1;
        begin
            nm1 = $signed({2'b00, n}) - 15'sd1;
            a = (t < 0) ? -t : t;
            if (a > nm1)
                a = (nm1 + nm1) - a;
            return a[12:0];
        end
    endfunction

    function automatic logic [7:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] r;
        begin
            v = (ACC_W+1)'(acc) + (ACC_W+1)'(1 <<< (WEIGHT_FRAC_BITS - 1));
            r = v >>> WEIGHT_FRAC_BITS;
            if (v < 0)
                return 8'd0;
            else if (r > 255)
                return 8'd255;
            else
                return r[7:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/image_convolution_reflect_border.sv
// Steps: tap load writes the kernel memory; pixel without output runs the 23-step row/column divider,
// then the ring write. Pixel or drain that emits: the divider again, (2N+1)^2 taps (one ring and
// one tap read per cycle, 225 at N=7), then the pipeline flush and the output register.
// Throughput: one item at a time; input is accepted only while the state machine is idle.
// Reset: counts, pipeline and output valid clear at once; ring and kernel memories are
// not cleared and must be written before use. Configuration resets to 800 x 600, N=7.
`default_nettype none
module image_convolution_reflect_border (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  tap_index,
    input  wire logic signed [15:0] tap_weight,
    input  wire logic [7:0]  chan0_in,
    input  wire logic [7:0]  chan1_in,
    input  wire logic [7:0]  chan2_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       chan0_out,
    output logic [7:0]       chan1_out,
    output logic [7:0]       chan2_out,
    output logic             frame_end
);
    import icrb_pkg::*;

    state_t state_reg, state_next;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  radius_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [23:0] total_full;
    logic [CNT_W-1:0] total;
    logic [13:0] lag;

    logic [CNT_W-1:0] incnt_reg;
    logic [CNT_W-1:0] outcnt_reg;

    logic [CNT_W-1:0] div_num_reg;
    logic [10:0]      div_rem_reg;
    logic [4:0]       div_cnt_reg;
    logic [11:0]      div_trial;
    logic             div_ge;
    logic             div_done;

    logic [23:0] pix_reg;
    logic [3:0]  ki_reg;
    logic [3:0]  kj_reg;
    logic [3:0]  side_last;
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic signed [PROD_W-1:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [ACC_W-1:0]  acc0_reg, acc1_reg, acc2_reg;
    logic        out_valid_reg;
    logic        frame_done;

    logic [23:0] ring_mem [RING_DEPTH];
    logic [15:0] tap_mem [TAP_COUNT];
    logic [23:0] ring_rd_reg;
    logic [15:0] tap_rd_reg;
    logic signed [14:0] ty_raw, tx_raw;
    logic [12:0] ty, tx;
    logic [13:0] ring_raddr;
    logic [7:0]  tap_raddr;

    logic accept;
    logic in_pixel_go, drain_emit, drain_restart, write_emit, emit_fire, last_tap;

    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;

    assign w_eff = (width_reg < 11'(MIN_DIM)) ? 11'(MIN_DIM) :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg < 13'(MIN_DIM)) ? 13'(MIN_DIM) :
                   (height_reg > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_reg;
    assign total_full = {13'd0, w_eff} * {11'd0, h_eff};
    assign total      = total_full[CNT_W-1:0];
    assign lag        = 14'(radius_reg) * 14'(w_eff) + 14'(radius_reg);
    assign side_last  = {radius_reg, 1'b0};

    assign div_trial = {div_rem_reg, div_num_reg[CNT_W-1]};
    assign div_ge    = div_trial >= {1'b0, w_eff};
    assign div_done  = (div_cnt_reg == 5'(DIV_STEPS - 1));

    assign ty_raw = $signed({2'b00, div_num_reg[12:0]}) + $signed({11'd0, ki_reg})
                  - $signed({12'd0, radius_reg});
    assign tx_raw = $signed({5'd0, div_rem_reg[9:0]}) + $signed({11'd0, kj_reg})
                  - $signed({12'd0, radius_reg});
    assign ty = mirror(ty_raw, h_eff);
    assign tx = mirror(tx_raw, {2'b00, w_eff});
    assign ring_raddr = {ty[3:0], tx[9:0]};
    assign tap_raddr  = 8'(ki_reg) * 8'(KSIDE) + 8'(kj_reg);
    assign last_tap   = (ki_reg == side_last) && (kj_reg == side_last);

    assign in_pixel_go   = accept && (op == OP_PIXEL) && (incnt_reg < total);
    assign drain_emit    = accept && (op == OP_DRAIN) && (incnt_reg >= total)
                         && (outcnt_reg < total);
    assign drain_restart = accept && (op == OP_DRAIN) && (incnt_reg >= total)
                         && (outcnt_reg >= total);
    assign write_emit    = (outcnt_reg < total)
                         && ({1'b0, incnt_reg} >= {1'b0, outcnt_reg} + 24'(lag));
    assign emit_fire     = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign frame_done    = ({1'b0, outcnt_reg} + 24'd1) >= {1'b0, total};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_pixel_go)
                    state_next = S_DIVI;
                else if (drain_emit)
                    state_next = S_DIVO;
            end
            S_DIVI:  if (div_done) state_next = S_WRITE;
            S_WRITE: state_next = write_emit ? S_DIVO : S_IDLE;
            S_DIVO:  if (div_done) state_next = S_TAPS;
            S_TAPS:  if (last_tap) state_next = S_FLUSH;
            S_FLUSH: if (!s1_valid_reg && !s2_valid_reg) state_next = S_EMIT;
            S_EMIT:  if (emit_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 11'd800;
            height_reg    <= 13'd600;
            radius_reg    <= 3'd7;
            incnt_reg     <= '0;
            outcnt_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_RADIUS: radius_reg <= cfg_data[2:0];
                    default:    ;
                endcase
            end
            if (drain_restart)
            begin
                incnt_reg  <= '0;
                outcnt_reg <= '0;
            end
            else if (state_reg == S_WRITE)
                incnt_reg <= incnt_reg + 1'b1;
            else if (emit_fire)
            begin
                if (frame_done)
                begin
                    incnt_reg  <= '0;
                    outcnt_reg <= '0;
                end
                else
                    outcnt_reg <= outcnt_reg + 1'b1;
            end
            s1_valid_reg <= (state_reg == S_TAPS);
            s2_valid_reg <= s1_valid_reg;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= {chan2_in, chan1_in, chan0_in};
        if ((state_reg == S_IDLE && (in_pixel_go || drain_emit))
            || (state_reg == S_WRITE && write_emit))
        begin
            div_num_reg <= (state_reg == S_IDLE && in_pixel_go) ? incnt_reg : outcnt_reg;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (state_reg == S_DIVI || state_reg == S_DIVO)
        begin
            div_num_reg <= {div_num_reg[CNT_W-2:0], div_ge};
            div_rem_reg <= div_ge ? 11'(div_trial - {1'b0, w_eff}) : div_trial[10:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == S_DIVO)
        begin
            ki_reg   <= '0;
            kj_reg   <= '0;
            acc0_reg <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else
        begin
            if (state_reg == S_TAPS)
            begin
                if (kj_reg == side_last)
                begin
                    kj_reg <= '0;
                    ki_reg <= ki_reg + 1'b1;
                end
                else
                    kj_reg <= kj_reg + 1'b1;
            end
            if (s2_valid_reg)
            begin
                acc0_reg <= acc0_reg + ACC_W'(prod0_reg);
                acc1_reg <= acc1_reg + ACC_W'(prod1_reg);
                acc2_reg <= acc2_reg + ACC_W'(prod2_reg);
            end
        end
        prod0_reg <= $signed({1'b0, ring_rd_reg[7:0]})   * $signed(tap_rd_reg);
        prod1_reg <= $signed({1'b0, ring_rd_reg[15:8]})  * $signed(tap_rd_reg);
        prod2_reg <= $signed({1'b0, ring_rd_reg[23:16]}) * $signed(tap_rd_reg);
        if (emit_fire)
        begin
            chan0_out <= round_sat(acc0_reg);
            chan1_out <= round_sat(acc1_reg);
            chan2_out <= round_sat(acc2_reg);
            frame_end <= frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            ring_mem[{div_num_reg[3:0], div_rem_reg[9:0]}] <= pix_reg;
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_TAP && tap_index < 8'(TAP_COUNT))
            tap_mem[tap_index] <= tap_weight;
        tap_rd_reg <= tap_mem[tap_raddr];
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
        outcnt_reg <= incnt_reg)
        else $error("output count passed input count");
    a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !s1_valid_reg && !s2_valid_reg)
        else $error("tap pipeline busy in idle");
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAPS |-> ki_reg <= side_last && kj_reg <= side_last)
        else $error("tap loop out of window");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_valid_reg && !out_ready |=> state_reg == S_EMIT)
        else $error("result dropped while output busy");
`endif

endmodule
`default_nettype wire
